/* hdl/spa_pkg.sv */
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the sparse polynomial adder: term store
// geometry, field widths, command codes, sequencer states and RAM write bundle.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 32;
  localparam int EXP_W     = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int ENTRY_W   = COEF_W + EXP_W;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MERGE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } ram_wr_t;

endpackage

/* hdl/spa_ram.sv */
// ----------------------------------------------------------------------------
// spa_ram
// Single term store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_ram (
  input  logic                         clk,
  input  spa_pkg::ram_wr_t             wr,
  input  logic [spa_pkg::IDX_W-1:0]    rd_addr,
  output logic [spa_pkg::ENTRY_W-1:0]  rd_data
);

  logic [spa_pkg::ENTRY_W-1:0] mem [spa_pkg::MAX_TERMS];
  logic [spa_pkg::ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/spa_seq.sv */
// ----------------------------------------------------------------------------
// spa_seq
// Merge sequencer: handles loads, walks both stores with one shared compare
// and add unit, and holds one pending term so the final one can be marked.
// ----------------------------------------------------------------------------
module spa_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_cmd,
  input  logic signed [spa_pkg::COEF_W-1:0]  in_term_coef,
  input  logic [spa_pkg::EXP_W-1:0]          in_term_exp,
  output spa_pkg::ram_wr_t                   wr_a,
  output spa_pkg::ram_wr_t                   wr_b,
  output logic [spa_pkg::IDX_W-1:0]          rd_addr_a,
  output logic [spa_pkg::IDX_W-1:0]          rd_addr_b,
  input  logic [spa_pkg::ENTRY_W-1:0]        rd_data_a,
  input  logic [spa_pkg::ENTRY_W-1:0]        rd_data_b,
  output logic                               out_strobe,
  output logic signed [spa_pkg::SUM_W-1:0]   out_sum_coef,
  output logic [spa_pkg::EXP_W-1:0]          out_sum_exp,
  output logic                               out_term_valid,
  output logic                               out_last_term
);

  spa_pkg::state_t state_r, state_nxt;

  logic [spa_pkg::CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [spa_pkg::CNT_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt;

  logic                             pend_valid_r, pend_valid_nxt;
  logic signed [spa_pkg::SUM_W-1:0] pend_coef_r, pend_coef_nxt;
  logic [spa_pkg::EXP_W-1:0]        pend_exp_r, pend_exp_nxt;

  logic                             strobe_r, strobe_nxt;
  logic signed [spa_pkg::SUM_W-1:0] coef_r, coef_nxt;
  logic [spa_pkg::EXP_W-1:0]        exp_r, exp_nxt;
  logic                             valid_r, valid_nxt;
  logic                             last_r, last_nxt;

  logic                             accept, a_live, b_live, use_a, use_b, emit;
  logic [spa_pkg::EXP_W-1:0]        ea, eb;
  logic signed [spa_pkg::SUM_W-1:0] opa, opb, sum;

  assign accept = start && (state_r == spa_pkg::ST_IDLE);
  assign busy   = (state_r != spa_pkg::ST_IDLE);

  assign a_live = (ia_r < cnt_a_r);
  assign b_live = (ib_r < cnt_b_r);
  assign ea     = rd_data_a[spa_pkg::ENTRY_W-1:spa_pkg::COEF_W];
  assign eb     = rd_data_b[spa_pkg::ENTRY_W-1:spa_pkg::COEF_W];
  assign use_a  = a_live && (!b_live || (ea >= eb));
  assign use_b  = b_live && (!a_live || (eb >= ea));

  assign opa  = use_a ? spa_pkg::SUM_W'(signed'(rd_data_a[spa_pkg::COEF_W-1:0])) : '0;
  assign opb  = use_b ? spa_pkg::SUM_W'(signed'(rd_data_b[spa_pkg::COEF_W-1:0])) : '0;
  assign sum  = opa + opb;
  assign emit = !(use_a && use_b) || (sum != '0);

  assign rd_addr_a = ia_r[spa_pkg::IDX_W-1:0];
  assign rd_addr_b = ib_r[spa_pkg::IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spa_pkg::ST_IDLE: begin
        if (accept && (in_cmd == spa_pkg::CMD_START)) begin
          state_nxt = spa_pkg::ST_FETCH;
        end
      end
      spa_pkg::ST_FETCH: begin
        state_nxt = spa_pkg::ST_MERGE;
      end
      spa_pkg::ST_MERGE: begin
        if (!a_live && !b_live) begin
          state_nxt = spa_pkg::ST_FINISH;
        end else begin
          state_nxt = spa_pkg::ST_FETCH;
        end
      end
      spa_pkg::ST_FINISH: begin
        state_nxt = spa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = spa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    pend_valid_nxt = pend_valid_r;
    pend_coef_nxt  = pend_coef_r;
    pend_exp_nxt   = pend_exp_r;
    strobe_nxt     = 1'b0;
    coef_nxt       = coef_r;
    exp_nxt        = exp_r;
    valid_nxt      = valid_r;
    last_nxt       = last_r;
    wr_a.we        = 1'b0;
    wr_a.addr      = cnt_a_r[spa_pkg::IDX_W-1:0];
    wr_a.data      = {in_term_exp, in_term_coef};
    wr_b.we        = 1'b0;
    wr_b.addr      = cnt_b_r[spa_pkg::IDX_W-1:0];
    wr_b.data      = {in_term_exp, in_term_coef};
    case (state_r)
      spa_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == spa_pkg::CMD_LOAD_A) begin
            if (cnt_a_r < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
              wr_a.we   = 1'b1;
              cnt_a_nxt = cnt_a_r + 1'b1;
            end
          end else if (in_cmd == spa_pkg::CMD_LOAD_B) begin
            if (cnt_b_r < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
              wr_b.we   = 1'b1;
              cnt_b_nxt = cnt_b_r + 1'b1;
            end
          end else if (in_cmd == spa_pkg::CMD_START) begin
            ia_nxt         = '0;
            ib_nxt         = '0;
            pend_valid_nxt = 1'b0;
          end
        end
      end
      spa_pkg::ST_FETCH: begin
      end
      spa_pkg::ST_MERGE: begin
        if (use_a) begin
          ia_nxt = ia_r + 1'b1;
        end
        if (use_b) begin
          ib_nxt = ib_r + 1'b1;
        end
        if ((a_live || b_live) && emit) begin
          if (pend_valid_r) begin
            strobe_nxt = 1'b1;
            coef_nxt   = pend_coef_r;
            exp_nxt    = pend_exp_r;
            valid_nxt  = 1'b1;
            last_nxt   = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_coef_nxt  = sum;
          pend_exp_nxt   = use_a ? ea : eb;
        end
      end
      spa_pkg::ST_FINISH: begin
        strobe_nxt     = 1'b1;
        coef_nxt       = pend_valid_r ? pend_coef_r : '0;
        exp_nxt        = pend_valid_r ? pend_exp_r : '0;
        valid_nxt      = pend_valid_r;
        last_nxt       = 1'b1;
        pend_valid_nxt = 1'b0;
        cnt_a_nxt      = '0;
        cnt_b_nxt      = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spa_pkg::ST_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      pend_valid_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      pend_valid_r <= pend_valid_nxt;
      strobe_r     <= strobe_nxt;
    end
    pend_coef_r <= pend_coef_nxt;
    pend_exp_r  <= pend_exp_nxt;
    coef_r      <= coef_nxt;
    exp_r       <= exp_nxt;
    valid_r     <= valid_nxt;
    last_r      <= last_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_sum_coef   = coef_r;
  assign out_sum_exp    = exp_r;
  assign out_term_valid = valid_r;
  assign out_last_term  = last_r;

endmodule

/* hdl/sparse_polynomial_adder.sv */
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// Adds two sparse polynomials held in two term stores by a sequential merge.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0 into A, cmd 1 into B) stores one term; terms past
// 32 per store are dropped. A start transaction (cmd 2) keeps busy high
// through its merge steps, of which there are at most count_a+count_b; each
// step passes through ST_FETCH for the registered store read and then
// ST_MERGE for the shared compare and add unit. Results leave on out_strobe,
// one cycle each, at most one per step, and cannot be held off; the final
// one carries out_last_term and appears in the same cycle as busy falls. An
// empty sum gives a single result with out_term_valid low. Both stores are
// empty afterwards. Unused command codes are ignored.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_cmd,
  input  logic signed [spa_pkg::COEF_W-1:0]  in_term_coef,
  input  logic [spa_pkg::EXP_W-1:0]          in_term_exp,
  output logic                               out_strobe,
  output logic signed [spa_pkg::SUM_W-1:0]   out_sum_coef,
  output logic [spa_pkg::EXP_W-1:0]          out_sum_exp,
  output logic                               out_term_valid,
  output logic                               out_last_term
);

  spa_pkg::ram_wr_t              wr_a, wr_b;
  logic [spa_pkg::IDX_W-1:0]     rd_addr_a, rd_addr_b;
  logic [spa_pkg::ENTRY_W-1:0]   rd_data_a, rd_data_b;

  spa_ram u_store_a (
    .clk     (clk),
    .wr      (wr_a),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  spa_ram u_store_b (
    .clk     (clk),
    .wr      (wr_b),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  spa_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_term_coef   (in_term_coef),
    .in_term_exp    (in_term_exp),
    .wr_a           (wr_a),
    .wr_b           (wr_b),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .rd_data_a      (rd_data_a),
    .rd_data_b      (rd_data_b),
    .out_strobe     (out_strobe),
    .out_sum_coef   (out_sum_coef),
    .out_sum_exp    (out_sum_exp),
    .out_term_valid (out_term_valid),
    .out_last_term  (out_last_term)
  );

endmodule

/* hdl/spa_checker.sv */
// ----------------------------------------------------------------------------
// spa_checker
// Port-level checks on the sparse polynomial adder, bound to the top level.
// ----------------------------------------------------------------------------
module spa_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [1:0]                         in_cmd,
  input logic                               out_strobe,
  input logic signed [spa_pkg::SUM_W-1:0]   out_sum_coef,
  input logic [spa_pkg::EXP_W-1:0]          out_sum_exp,
  input logic                               out_term_valid,
  input logic                               out_last_term
);

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_term_valid |-> out_last_term)
    else $error("empty result not marked last");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_term_valid |-> (out_sum_coef == '0) && (out_sum_exp == '0))
    else $error("empty result carries a term");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == spa_pkg::CMD_START) |=> busy)
    else $error("start transaction did not raise busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_term |-> busy)
    else $error("intermediate result outside a run");

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .out_strobe     (out_strobe),
  .out_sum_coef   (out_sum_coef),
  .out_sum_exp    (out_sum_exp),
  .out_term_valid (out_term_valid),
  .out_last_term  (out_last_term)
);
